>>> rtl/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Shared constants, register indexes and types of the sensor compensation.
// ----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_TEMP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_A   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_B   = 3'd4;

  localparam logic [31:0] TFINE_PRESS_OFS  = 32'd128000;
  localparam logic [31:0] PRESS_FULL_SCALE = 32'd1048576;
  localparam logic [31:0] PRESS_SCALE      = 32'd3125;
  localparam logic [31:0] TFINE_HUM_OFS    = 32'd76800;
  localparam logic [31:0] HUM_MAX_Q12      = 32'd419430400;
  localparam logic [31:0] HUM_GAIN_OFS     = 32'd2097152;

  // one quotient bit per divider stage
  localparam int unsigned DIV_STAGES = 64;
  localparam int unsigned PRESS_LAT  = DIV_STAGES + 14;

  typedef struct packed {
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } esc_press_coef_t;

  typedef struct packed {
    logic [15:0] tc;
    logic [16:0] hum;
  } esc_th_word_t;

endpackage

`default_nettype wire

>>> rtl/esc_press.sv
// ----------------------------------------------------------------------------
// esc_press
// Pipelined 64-bit pressure compensation with a one-bit-per-stage divider.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_press (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     valid_i,
  input  wire logic signed [31:0]       t_fine_i,
  input  wire logic [19:0]              raw_pressure_i,
  input  wire esc_pkg::esc_press_coef_t coef_i,
  output logic                          valid_o,
  output logic [31:0]                   pressure_o,
  output logic                          invalid_o
);
  import esc_pkg::*;

  logic signed [63:0] p1w, p2w, p3w, p4w, p5w, p6w, p7w, p8w, p9w;
  assign p1w = {48'd0, coef_i.p1};
  assign p2w = 64'($signed(coef_i.p2));
  assign p3w = 64'($signed(coef_i.p3));
  assign p4w = 64'($signed(coef_i.p4));
  assign p5w = 64'($signed(coef_i.p5));
  assign p6w = 64'($signed(coef_i.p6));
  assign p7w = 64'($signed(coef_i.p7));
  assign p8w = 64'($signed(coef_i.p8));
  assign p9w = 64'($signed(coef_i.p9));

  logic [PRESS_LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PRESS_LAT-2:0], valid_i};
    end
  end
  assign valid_o = vld_q[PRESS_LAT-1];

  // front end: offsets and coefficient products
  logic signed [32:0] a_q;
  logic signed [63:0] aa_q, ap5_q, ap2_q, b1_q, a1_q, ap5b_q, ap2b_q;
  logic signed [63:0] b_q, a2_q, a3_q, num_q, den_q, numm_q;
  logic [19:0]        adc1_q, adc2_q, adc3_q, adc4_q;
  logic signed [63:0] pd;

  assign pd = 64'(PRESS_FULL_SCALE) - {44'd0, adc4_q};

  always_ff @(posedge clk_i) begin
    a_q    <= {t_fine_i[31], t_fine_i} - 33'(TFINE_PRESS_OFS);
    adc1_q <= raw_pressure_i;

    aa_q   <= 64'(a_q) * 64'(a_q);
    ap5_q  <= 64'(a_q) * p5w;
    ap2_q  <= 64'(a_q) * p2w;
    adc2_q <= adc1_q;

    b1_q   <= aa_q * p6w;
    a1_q   <= aa_q * p3w;
    ap5b_q <= ap5_q;
    ap2b_q <= ap2_q;
    adc3_q <= adc2_q;

    b_q    <= b1_q + (ap5b_q <<< 17) + (p4w <<< 35);
    a2_q   <= (a1_q >>> 8) + (ap2b_q <<< 12);
    adc4_q <= adc3_q;

    a3_q   <= (a2_q + (64'sd1 <<< 47)) * p1w;
    num_q  <= (pd <<< 31) - b_q;

    den_q  <= a3_q >>> 33;
    numm_q <= num_q * 64'(PRESS_SCALE);
  end

  // restoring divider on magnitudes
  logic [63:0] drem_q [DIV_STAGES+1];
  logic [63:0] dnq_q  [DIV_STAGES+1];
  logic [63:0] dmb_q  [DIV_STAGES+1];
  logic        dneg_q [DIV_STAGES+1];
  logic        dinv_q [DIV_STAGES+1];

  always_ff @(posedge clk_i) begin
    drem_q[0] <= '0;
    dnq_q[0]  <= numm_q[63] ? 64'(-numm_q) : numm_q;
    dmb_q[0]  <= den_q[63] ? 64'(-den_q) : den_q;
    dneg_q[0] <= numm_q[63] ^ den_q[63];
    dinv_q[0] <= (den_q == '0);
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic [64:0] sh;
    logic        ge;
    assign sh = {drem_q[k], dnq_q[k][63]};
    assign ge = (sh >= {1'b0, dmb_q[k]});

    always_ff @(posedge clk_i) begin
      drem_q[k+1] <= ge ? 64'(sh - {1'b0, dmb_q[k]}) : sh[63:0];
      dnq_q[k+1]  <= {dnq_q[k][62:0], ge};
      dmb_q[k+1]  <= dmb_q[k];
      dneg_q[k+1] <= dneg_q[k];
      dinv_q[k+1] <= dinv_q[k];
    end
  end

  // back end: corrections and saturation
  logic signed [63:0] p8_q, p9_q, p10_q, p11_q, p12_q;
  logic signed [63:0] ps9_q, ps10_q, c2_9_q, c2_10_q, c2_11_q, c2_12_q;
  logic signed [63:0] t10_q, ll_q, c1_q, s_q, pc2;
  logic [31:0]        cr_q;
  logic               inv8_q, inv9_q, inv10_q, inv11_q, inv12_q, inv13_q;
  logic [63:0]        qv;

  assign qv  = dnq_q[DIV_STAGES];
  assign pc2 = p8w * p8_q;

  always_ff @(posedge clk_i) begin
    p8_q    <= dneg_q[DIV_STAGES] ? $signed(64'(-qv)) : $signed(qv);
    inv8_q  <= dinv_q[DIV_STAGES];

    p9_q    <= p8_q;
    ps9_q   <= p8_q >>> 13;
    c2_9_q  <= pc2 >>> 19;
    inv9_q  <= inv8_q;

    t10_q   <= p9w * ps9_q;
    p10_q   <= p9_q;
    ps10_q  <= ps9_q;
    c2_10_q <= c2_9_q;
    inv10_q <= inv9_q;

    ll_q    <= 64'(t10_q[31:0]) * 64'(ps10_q[31:0]);
    cr_q    <= t10_q[31:0] * ps10_q[63:32] + t10_q[63:32] * ps10_q[31:0];
    p11_q   <= p10_q;
    c2_11_q <= c2_10_q;
    inv11_q <= inv10_q;

    c1_q    <= $signed(ll_q + {cr_q, 32'd0}) >>> 25;
    p12_q   <= p11_q;
    c2_12_q <= c2_11_q;
    inv12_q <= inv11_q;

    s_q     <= ((p12_q + c1_q + c2_12_q) >>> 8) + (p7w <<< 4);
    inv13_q <= inv12_q;

    if (inv13_q || s_q[63]) begin
      pressure_o <= '0;
    end else if (s_q > 64'sd4294967295) begin
      pressure_o <= '1;
    end else begin
      pressure_o <= s_q[31:0];
    end
    invalid_o <= inv13_q;
  end

endmodule

`default_nettype wire

>>> rtl/env_sensor_compensation.sv
// ----------------------------------------------------------------------------
// env_sensor_compensation
// Integer compensation of raw temperature, pressure and humidity readings.
// ----------------------------------------------------------------------------
// A reading is taken on every cycle with start high (busy never rises) and
// its compensated word appears with result_valid_o after the fine
// temperature stages and then the pressure path, whose depth is set by the
// 64-stage divider. Temperature and humidity are computed alongside and
// delayed to match. Results cannot be held off. Coefficients must be
// written only while no reading is in flight; the block does not enforce it.
`default_nettype none

module env_sensor_compensation (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [19:0]                    raw_temperature_i,
  input  wire logic [19:0]                    raw_pressure_i,
  input  wire logic [15:0]                    raw_humidity_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [esc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [esc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                                result_valid_o,
  output logic signed [15:0]                  temperature_centi_o,
  output logic [31:0]                         pressure_q24_8_o,
  output logic [16:0]                         humidity_q22_10_o,
  output logic                                pressure_invalid_o
);
  import esc_pkg::*;

  localparam int unsigned HUM_LAT   = 11;
  localparam int unsigned DLY       = PRESS_LAT - HUM_LAT;
  localparam int unsigned TOTAL_LAT = PRESS_LAT + 4;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // coefficient registers
  logic [47:0] temp_q;
  logic [63:0] press_a_q, press_b_q;
  logic [55:0] hum_a_q;
  logic [31:0] hum_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q    <= '0;
      press_a_q <= '0;
      press_b_q <= '0;
      hum_a_q   <= '0;
      hum_b_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TEMP:    temp_q    <= cfg_wdata_i[47:0];
        REG_PRESS_A: press_a_q <= cfg_wdata_i;
        REG_PRESS_B: press_b_q <= cfg_wdata_i;
        REG_HUM_A:   hum_a_q   <= cfg_wdata_i[55:0];
        REG_HUM_B:   hum_b_q   <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  logic signed [31:0] t2w, t3w, h2w, h1w, h3w, h6w, h5w;
  assign t2w = 32'($signed(temp_q[31:16]));
  assign t3w = 32'($signed(temp_q[47:32]));
  assign h2w = 32'($signed(hum_a_q[31:16]));
  assign h1w = {24'd0, hum_a_q[39:32]};
  assign h3w = {24'd0, hum_a_q[47:40]};
  assign h6w = 32'($signed(hum_a_q[55:48]));
  assign h5w = 32'($signed(hum_b_q[31:16]));

  esc_press_coef_t pcoef;
  assign pcoef = '{p1: press_a_q[15:0],  p2: press_a_q[31:16],
                   p3: press_a_q[47:32], p4: press_a_q[63:48],
                   p5: press_b_q[15:0],  p6: press_b_q[31:16],
                   p7: press_b_q[47:32], p8: press_b_q[63:48],
                   p9: hum_a_q[15:0]};

  // fine temperature
  logic [3:0]         tv_q;
  logic signed [31:0] d1_q, d2_q, m1_q, m2_q, v1_q, m3_q, tfine_q;
  logic [19:0]        rp1_q, rp2_q, rp3_q, rp4_q;
  logic [15:0]        rh1_q, rh2_q, rh3_q, rh4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q <= '0;
    end else begin
      tv_q <= {tv_q[2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    d1_q    <= $signed({15'd0, raw_temperature_i[19:3]}) - $signed({15'd0, temp_q[15:0], 1'b0});
    d2_q    <= $signed({16'd0, raw_temperature_i[19:4]}) - $signed({16'd0, temp_q[15:0]});
    rp1_q   <= raw_pressure_i;
    rh1_q   <= raw_humidity_i;

    m1_q    <= d1_q * t2w;
    m2_q    <= d2_q * d2_q;
    rp2_q   <= rp1_q;
    rh2_q   <= rh1_q;

    v1_q    <= m1_q >>> 11;
    m3_q    <= (m2_q >>> 12) * t3w;
    rp3_q   <= rp2_q;
    rh3_q   <= rh2_q;

    tfine_q <= v1_q + (m3_q >>> 14);
    rp4_q   <= rp3_q;
    rh4_q   <= rh3_q;
  end

  // pressure
  logic        pv;
  logic [31:0] pres;
  logic        pinv;

  esc_press u_press (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (tv_q[3]),
    .t_fine_i       (tfine_q),
    .raw_pressure_i (rp4_q),
    .coef_i         (pcoef),
    .valid_o        (pv),
    .pressure_o     (pres),
    .invalid_o      (pinv)
  );

  // temperature output and humidity
  logic signed [31:0] t5, tcw;
  logic [15:0]        tc_d;
  assign t5  = tfine_q + (tfine_q <<< 2) + 32'sd128;
  assign tcw = t5 >>> 8;

  always_comb begin
    if (tcw < -32'sd32768) begin
      tc_d = 16'h8000;
    end else if (tcw > 32'sd32767) begin
      tc_d = 16'h7fff;
    end else begin
      tc_d = tcw[15:0];
    end
  end

  logic [15:0]        tc_q [HUM_LAT];
  logic signed [31:0] hv_q, x0_q, x0d_q, mh5_q, mh6_q, mh3_q, x_q [3:7];
  logic signed [31:0] y0_q, z_q, yz_q, y1_q, y2m_q, y_q, v2_q [8:10];
  logic signed [31:0] qq_q, q1m_q, q0, vf;
  logic [16:0]        hum_q;

  assign q0 = v2_q[8] >>> 15;
  assign vf = v2_q[10] - (q1m_q >>> 4);

  always_ff @(posedge clk_i) begin
    tc_q[0] <= tc_d;
    for (int i = 1; i < HUM_LAT; i++) begin
      tc_q[i] <= tc_q[i-1];
    end

    hv_q   <= tfine_q - $signed(TFINE_HUM_OFS);
    x0_q   <= $signed({2'd0, rh4_q, 14'd0}) - $signed({hum_b_q[11:0], 20'd0});

    mh5_q  <= h5w * hv_q;
    mh6_q  <= hv_q * h6w;
    mh3_q  <= hv_q * h3w;
    x0d_q  <= x0_q;

    x_q[3] <= (x0d_q - mh5_q + 32'sd16384) >>> 15;
    y0_q   <= mh6_q >>> 10;
    z_q    <= (mh3_q >>> 11) + 32'sd32768;

    x_q[4] <= x_q[3];
    yz_q   <= y0_q * z_q;

    x_q[5] <= x_q[4];
    y1_q   <= (yz_q >>> 10) + $signed(HUM_GAIN_OFS);

    x_q[6] <= x_q[5];
    y2m_q  <= y1_q * h2w;

    x_q[7] <= x_q[6];
    y_q    <= (y2m_q + 32'sd8192) >>> 14;

    v2_q[8]  <= x_q[7] * y_q;

    qq_q     <= q0 * q0;
    v2_q[9]  <= v2_q[8];

    q1m_q    <= (qq_q >>> 7) * h1w;
    v2_q[10] <= v2_q[9];

    if (vf[31]) begin
      hum_q <= '0;
    end else if (vf > $signed(HUM_MAX_Q12)) begin
      hum_q <= HUM_MAX_Q12[28:12];
    end else begin
      hum_q <= vf[28:12];
    end
  end

  // align temperature and humidity with the pressure path
  esc_th_word_t dl_q [DLY];

  always_ff @(posedge clk_i) begin
    dl_q[0] <= '{tc: tc_q[HUM_LAT-1], hum: hum_q};
    for (int i = 1; i < DLY; i++) begin
      dl_q[i] <= dl_q[i-1];
    end
  end

  assign result_valid_o      = pv;
  assign pressure_q24_8_o    = pres;
  assign pressure_invalid_o  = pinv;
  assign temperature_centi_o = dl_q[DLY-1].tc;
  assign humidity_q22_10_o   = dl_q[DLY-1].hum;

  a_fixed_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(accept, TOTAL_LAT))
    else $error("result word without a matching reading");

  a_no_loss : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##TOTAL_LAT result_valid_o)
    else $error("reading lost in the pipeline");

  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && pressure_invalid_o) |-> (pressure_q24_8_o == '0))
    else $error("invalid pressure not zero");

  a_hum_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (humidity_q22_10_o <= 17'd102400))
    else $error("humidity above full scale");

endmodule

`default_nettype wire
